>>> design/gde_pkg.sv
// Shared constants, types and the 2^-f lookup table for the Gaussian density pipeline.
package gde_pkg;

    localparam int unsigned EXP_TABLE_DEPTH = 256;
    localparam int          IDX_W           = $clog2(EXP_TABLE_DEPTH);

    localparam int WORD_W      = 32;
    localparam int T_W         = 48;
    localparam int CFG_INDEX_W = 4;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN          = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_INV_TWO_VAR   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_PREFACTOR     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_PREFACTOR = CFG_INDEX_W'(3);

    // Register reset values
    localparam logic [WORD_W-1:0] MEAN_RST          = 32'd0;
    localparam logic [WORD_W-1:0] INV_TWO_VAR_RST   = 32'd32768;
    localparam logic [WORD_W-1:0] PREFACTOR_RST     = 32'd26145;
    localparam logic [WORD_W-1:0] LOG_PREFACTOR_RST = 32'hFFFF_14BE;

    // Fixed-point constants (Q32)
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

    // t at or above 2^T_SMALL_W (64.0 in Q16.16) gives zero density
    localparam int T_SMALL_W = 22;
    localparam int U_W       = 23;
    localparam int N_W       = U_W - 16;
    localparam logic [N_W-1:0] SHIFT_LIMIT = N_W'(40);

    localparam logic [WORD_W-1:0] LOG_MIN = 32'h8000_0000;

    typedef logic [32:0]    exp_entry_t;
    typedef exp_entry_t     exp_table_t [EXP_TABLE_DEPTH];

    // word passed from the quadratic front end to the exp/log back end
    typedef struct packed {
        logic           valid;
        logic [T_W-1:0] t;
    } term_word_t;

    // exp(-z) for Q32 z by a truncated 13-term series
    function automatic exp_entry_t exp_neg_q32(input logic [63:0] z);
        logic signed [64:0] sum;
        logic [63:0]        term;
        logic [63:0]        prod;
        sum  = 65'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k < 13; k++)
        begin
            prod = (term * z) >> 32;
            case (k)
                1:       term = prod;
                2:       term = prod / 64'd2;
                3:       term = prod / 64'd3;
                4:       term = prod / 64'd4;
                5:       term = prod / 64'd5;
                6:       term = prod / 64'd6;
                7:       term = prod / 64'd7;
                8:       term = prod / 64'd8;
                9:       term = prod / 64'd9;
                10:      term = prod / 64'd10;
                11:      term = prod / 64'd11;
                default: term = prod / 64'd12;
            endcase
            if (k % 2 == 1)
                sum = sum - $signed({1'b0, term});
            else
                sum = sum + $signed({1'b0, term});
        end
        return (sum < 0) ? '0 : sum[32:0];
    endfunction

    // entry i holds 2^(-i/EXP_TABLE_DEPTH) as unsigned Q1.32
    function automatic exp_table_t build_exp_table();
        exp_table_t tab;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            tab[i] = exp_neg_q32((64'(i) * LN2_Q32) / EXP_TABLE_DEPTH);
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

>>> design/gde_quad.sv
// Front end: t = (x - mean)^2 * inv_two_var in four register stages.
module gde_quad (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [31:0]    sample,
    input  logic signed [31:0]    mean,
    input  logic [31:0]           inv_two_var,
    output gde_pkg::term_word_t   term_out
);
    import gde_pkg::*;

    logic [3:0]        valid_reg;
    logic [3:0]        valid_next;

    logic [31:0]       abs_reg;
    logic [31:0]       abs_next;
    logic [63:0]       sq_reg;
    logic [63:0]       sq_next;
    logic [63:0]       phi_reg;
    logic [63:0]       phi_next;
    logic [63:0]       plo_reg;
    logic [63:0]       plo_next;
    logic [T_W-1:0]    t_reg;
    logic [T_W-1:0]    t_next;

    logic signed [32:0] diff;
    logic [32:0]        diff_neg;
    logic [63:0]        psum;

    // stage 1: |x - mean|, fits 32 bits
    always_comb
    begin
        diff     = $signed({sample[31], sample}) - $signed({mean[31], mean});
        diff_neg = -diff;
        abs_next = diff[32] ? diff_neg[31:0] : diff[31:0];
    end

    // stage 2: square, exact Q32.32
    assign sq_next = {32'b0, abs_reg} * {32'b0, abs_reg};

    // stage 3: high and low halves times inv_two_var
    assign phi_next = {32'b0, sq_reg[63:32]} * {32'b0, inv_two_var};
    assign plo_next = {32'b0, sq_reg[31:0]} * {32'b0, inv_two_var};

    // stage 4: combine and drop 48 fraction bits
    always_comb
    begin
        psum   = phi_reg + {32'b0, plo_reg[63:32]};
        t_next = psum[63:16];
    end

    assign valid_next = {valid_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= abs_next;
        sq_reg  <= sq_next;
        phi_reg <= phi_next;
        plo_reg <= plo_next;
        t_reg   <= t_next;
    end

    assign term_out.valid = valid_reg[3];
    assign term_out.t     = t_reg;

endmodule

>>> design/gde_eval.sv
// Back end: log density with clamp, and prefactor * 2^-u via table and shift.
module gde_eval (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gde_pkg::term_word_t   term_in,
    input  logic [31:0]           prefactor,
    input  logic signed [31:0]    log_prefactor,
    output logic                  done,
    output logic [31:0]           density,
    output logic signed [31:0]    log_density,
    output logic                  saturated
);
    import gde_pkg::*;

    logic [2:0]         valid_reg;
    logic [2:0]         valid_next;

    // stage 5 registers
    logic [U_W-1:0]     u_reg;
    logic [U_W-1:0]     u_next;
    logic               small_reg;
    logic               small_next;
    logic [WORD_W-1:0]  ld5_reg;
    logic [WORD_W-1:0]  ld5_next;
    logic               sat5_reg;
    logic               sat5_next;

    // stage 6 registers
    logic [32:0]        e_reg;
    logic [32:0]        e_next;
    logic [WORD_W-1:0]  ld6_reg;
    logic               sat6_reg;

    // stage 7 registers
    logic [WORD_W-1:0]  dens_reg;
    logic [WORD_W-1:0]  dens_next;
    logic [WORD_W-1:0]  ld7_reg;
    logic               sat7_reg;

    logic [49:0]        ld_full;
    logic [54:0]        u_prod;
    logic [N_W-1:0]     shift_n;
    logic [31:0]        idx_prod;
    logic [IDX_W-1:0]   idx;
    exp_entry_t         entry;
    logic [64:0]        dens_prod;

    // stage 5: log path with clamp, and u = t * log2(e)
    always_comb
    begin
        ld_full    = {{18{log_prefactor[31]}}, log_prefactor} - {2'b0, term_in.t};
        sat5_next  = ld_full[49] & ~(&ld_full[48:31]);
        ld5_next   = sat5_next ? LOG_MIN : ld_full[31:0];
        small_next = (term_in.t[T_W-1:T_SMALL_W] == '0);
        u_prod     = {33'b0, term_in.t[T_SMALL_W-1:0]} * {22'b0, LOG2E_Q32};
        u_next     = u_prod[32 +: U_W];
    end

    // stage 6: table lookup on the fraction, shift by the integer part
    always_comb
    begin
        shift_n  = u_reg[U_W-1:16];
        idx_prod = {16'b0, u_reg[15:0]} * 32'(EXP_TABLE_DEPTH);
        idx      = idx_prod[16 +: IDX_W];
        entry    = EXP_TABLE[idx];
        if (small_reg && (shift_n < SHIFT_LIMIT))
            e_next = entry >> shift_n;
        else
            e_next = '0;
    end

    // stage 7: scale by prefactor
    always_comb
    begin
        dens_prod = {33'b0, prefactor} * {32'b0, e_reg};
        dens_next = dens_prod[63:32];
    end

    assign valid_next = {valid_reg[1:0], term_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        small_reg <= small_next;
        ld5_reg   <= ld5_next;
        sat5_reg  <= sat5_next;
        e_reg     <= e_next;
        ld6_reg   <= ld5_reg;
        sat6_reg  <= sat5_reg;
        dens_reg  <= dens_next;
        ld7_reg   <= ld6_reg;
        sat7_reg  <= sat6_reg;
    end

    assign done        = valid_reg[2];
    assign density     = dens_reg;
    assign log_density = $signed(ld7_reg);
    assign saturated   = sat7_reg;

endmodule

>>> design/gaussian_density_eval.sv
// Top level: config registers, quadratic front end and exp/log back end.
// done is high while the result word of an accepted sample is on the ports.
// Throughput: one sample per cycle; busy stays low, seven register stages
// carry the two multiplier ranks, the table lookup and the prefactor multiply.
// The receiver cannot stall; each result word is on the ports for one cycle.
// Reset (rst_n low, async) empties the pipeline and loads default parameters.
module gaussian_density_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                sample,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gde_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    output logic                              done,
    output logic [31:0]                       density,
    output logic signed [31:0]                log_density,
    output logic                              saturated
);
    import gde_pkg::*;

    logic [WORD_W-1:0] mean_reg;
    logic [WORD_W-1:0] mean_next;
    logic [WORD_W-1:0] itv_reg;
    logic [WORD_W-1:0] itv_next;
    logic [WORD_W-1:0] pref_reg;
    logic [WORD_W-1:0] pref_next;
    logic [WORD_W-1:0] lpref_reg;
    logic [WORD_W-1:0] lpref_next;

    logic       accept;
    term_word_t term_word;

    // pipeline takes a word every cycle
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // config register decode
    always_comb
    begin
        mean_next  = mean_reg;
        itv_next   = itv_reg;
        pref_next  = pref_reg;
        lpref_next = lpref_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MEAN:          mean_next  = cfg_data;
                REG_INV_TWO_VAR:   itv_next   = cfg_data;
                REG_PREFACTOR:     pref_next  = cfg_data;
                REG_LOG_PREFACTOR: lpref_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= MEAN_RST;
            itv_reg   <= INV_TWO_VAR_RST;
            pref_reg  <= PREFACTOR_RST;
            lpref_reg <= LOG_PREFACTOR_RST;
        end
        else
        begin
            mean_reg  <= mean_next;
            itv_reg   <= itv_next;
            pref_reg  <= pref_next;
            lpref_reg <= lpref_next;
        end
    end

    gde_quad u_quad (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .sample      (sample),
        .mean        ($signed(mean_reg)),
        .inv_two_var (itv_reg),
        .term_out    (term_word)
    );

    gde_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .term_in       (term_word),
        .prefactor     (pref_reg),
        .log_prefactor ($signed(lpref_reg)),
        .done          (done),
        .density       (density),
        .log_density   (log_density),
        .saturated     (saturated)
    );

    // every result traces back to an earlier accepted sample
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result strobe without matching accepted sample");

    // a clamped result carries the minimum log density
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (log_density == $signed(LOG_MIN)))
        else $error("saturated flag set but log_density not at minimum");

    // above the minimum the clamp flag stays clear
    a_sat_only_at_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (log_density != $signed(LOG_MIN))) |-> !saturated)
        else $error("saturated flag set on unclamped log_density");

endmodule

>>> bench/gde_checker.sv
`timescale 1ns / 1ps
// Checker for the Gaussian density block: predicts every result word and compares it.
module gde_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [31:0]                       sample,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [gde_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              done,
    input  logic [31:0]                       density,
    input  logic [31:0]                       log_density,
    input  logic                              saturated,
    output int                                pending,
    output int                                fail_count
);
    import gde_pkg::*;

    localparam logic [63:0]        LN2_FX     = 64'd2977044472;
    localparam logic [63:0]        LOG2E_FX   = 64'd6196328019;
    localparam logic [47:0]        T_CUTOFF   = 48'h40_0000;
    localparam logic [63:0]        MAX_SHIFT  = 64'd40;
    localparam int                 SERIES_LEN = 13;
    localparam logic signed [63:0] LOG_FLOOR  = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] density;
        logic [31:0] log_density;
        logic        saturated;
    } density_word_t;

    // 2^(-i/depth) as Q1.32, filled once at time zero
    logic [63:0] pow2_frac [EXP_TABLE_DEPTH];

    // shadow copy of the config registers
    logic [31:0] mean_q          = MEAN_RST;
    logic [31:0] inv_two_var_q   = INV_TWO_VAR_RST;
    logic [31:0] prefactor_q     = PREFACTOR_RST;
    logic [31:0] log_prefactor_q = LOG_PREFACTOR_RST;

    density_word_t words_due [$];
    int accepted_total = 0;
    int retired_total  = 0;
    int mismatch_total = 0;

    assign pending    = accepted_total - retired_total;
    assign fail_count = mismatch_total + pending;

    // exp(-z), z in Q32, by the truncated alternating series
    function automatic logic [63:0] neg_exp_series(input logic [63:0] z);
        logic signed [64:0] acc;
        logic [63:0]        term;
        acc  = 65'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k < SERIES_LEN; k++)
        begin
            term = ((term * z) >> 32) / 64'(k);
            if (k % 2 == 1)
                acc = acc - $signed({1'b0, term});
            else
                acc = acc + $signed({1'b0, term});
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    initial
    begin
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            pow2_frac[i] = neg_exp_series((64'(i) * LN2_FX) / 64'(EXP_TABLE_DEPTH));
    end

    // density, log density and clamp flag for one sample under the current registers
    function automatic density_word_t predict_density(input logic [31:0] x);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [63:0]        sq;
        logic [95:0]        scaled;
        logic [47:0]        t;
        logic signed [63:0] ld;
        logic [63:0]        u;
        logic [63:0]        n;
        logic [63:0]        idx;
        logic [63:0]        e;
        density_word_t      w;
        diff   = $signed({x[31], x}) - $signed({mean_q[31], mean_q});
        mag    = diff[32] ? 33'(-diff) : 33'(diff);
        sq     = 64'(mag) * 64'(mag);
        scaled = 96'(sq) * 96'(inv_two_var_q);
        t      = scaled[95:48];

        // log side: subtract and clamp at the floor
        ld = $signed({{32{log_prefactor_q[31]}}, log_prefactor_q}) - $signed({16'd0, t});
        w.saturated = 1'b0;
        if (ld < LOG_FLOOR)
        begin
            ld          = LOG_FLOOR;
            w.saturated = 1'b1;
        end
        w.log_density = ld[31:0];

        // exp side: 2^-u split into shift and table fraction
        w.density = '0;
        if (t < T_CUTOFF)
        begin
            u   = (64'(t) * LOG2E_FX) >> 32;
            n   = u >> 16;
            idx = ((u & 64'hFFFF) * 64'(EXP_TABLE_DEPTH)) >> 16;
            if (n < MAX_SHIFT && idx < 64'(EXP_TABLE_DEPTH))
            begin
                e         = pow2_frac[idx] >> n;
                w.density = 32'((64'(prefactor_q) * e) >> 32);
            end
        end
        return w;
    endfunction

    // watch results, accepted samples and register writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        density_word_t want;
        if (!rst_n)
        begin
            mean_q          = MEAN_RST;
            inv_two_var_q   = INV_TWO_VAR_RST;
            prefactor_q     = PREFACTOR_RST;
            log_prefactor_q = LOG_PREFACTOR_RST;
            words_due.delete();
            accepted_total <= 0;
            retired_total  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (words_due.size() == 0)
                begin
                    $error("result word with none expected: density %h log_density %h sat %b",
                           density, log_density, saturated);
                    mismatch_total++;
                end
                else
                begin
                    want = words_due.pop_front();
                    retired_total <= retired_total + 1;
                    if (density !== want.density)
                    begin
                        $error("density: expected %h, got %h", want.density, density);
                        mismatch_total++;
                    end
                    if (log_density !== want.log_density)
                    begin
                        $error("log_density: expected %0d, got %0d",
                               $signed(want.log_density), $signed(log_density));
                        mismatch_total++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %b, got %b", want.saturated, saturated);
                        mismatch_total++;
                    end
                end
            end

            if (start && !busy)
            begin
                words_due.push_back(predict_density(sample));
                accepted_total <= accepted_total + 1;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MEAN:          mean_q          = cfg_data;
                    REG_INV_TWO_VAR:   inv_two_var_q   = cfg_data;
                    REG_PREFACTOR:     prefactor_q     = cfg_data;
                    REG_LOG_PREFACTOR: log_prefactor_q = cfg_data;
                    default:           ;
                endcase
            end
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Bench top for the Gaussian density block: clock, reset, stimulus and verdict.
module tb;
    import gde_pkg::*;

    localparam int RANDOM_ITEMS  = 750;
    localparam int PHASES        = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 200000;

    typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic signed [31:0]      sample    = '0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [31:0]             cfg_data  = '0;
    wire                     busy;
    wire                     cfg_ready;
    wire                     done;
    wire [31:0]              density;
    wire signed [31:0]       log_density;
    wire                     saturated;
    int                      pending;
    int                      fail_count;
    int                      cycle_count = 0;

    idle_mode_t  idle_mode = IDLE_NONE;
    logic [31:0] mean_set  = MEAN_RST;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    gaussian_density_eval dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .density     (density),
        .log_density (log_density),
        .saturated   (saturated)
    );

    gde_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .density     (density),
        .log_density (log_density),
        .saturated   (saturated),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one register write; cfg_valid goes low between writes, which keeps valid edges apart
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MEAN)
            mean_set = value;
    endtask

    // one sample word, with an optional gap ahead of it
    task automatic send_sample(input logic [31:0] value);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_HEAVY) ? 47 : (idle_mode == IDLE_LIGHT) ? 12 : 0;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start  <= 1'b1;
        sample <= value;
        do @(posedge clk); while (busy);
    endtask

    // hold off until every expected word is back, then let the pipe settle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] m, input logic [31:0] inv,
                                 input logic [31:0] pref, input logic [31:0] logp);
        write_reg(REG_MEAN, m);
        write_reg(REG_INV_TWO_VAR, inv);
        write_reg(REG_PREFACTOR, pref);
        write_reg(REG_LOG_PREFACTOR, logp);
        repeat (2) @(posedge clk);
    endtask

    // random registers, extremes mixed in; sometimes a write to an unused index
    task automatic random_setting();
        logic [31:0] m;
        logic [31:0] inv;
        logic [31:0] pref;
        logic [31:0] logp;
        case ($urandom_range(0, 3))
            0:       m = $urandom;
            1:       m = 32'($signed($urandom) >>> $urandom_range(8, 31));
            2:       m = 32'h7FFF_FFFF;
            default: m = 32'h8000_0000;
        endcase
        case ($urandom_range(0, 5))
            0:       inv = 32'd0;
            1:       inv = 32'hFFFF_FFFF;
            default: inv = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 3))
            0:       pref = 32'hFFFF_FFFF;
            1:       pref = $urandom;
            default: pref = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 4))
            0:       logp = 32'h8000_0000;
            1:       logp = 32'h7FFF_FFFF;
            2:       logp = $urandom;
            default: logp = 32'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
        apply_setting(m, inv, pref, logp);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_INDEX_W'($urandom_range(4, 15)), $urandom);
            repeat (2) @(posedge clk);
        end
    endtask

    // offsets of every magnitude around the current mean
    function automatic logic [31:0] near_mean();
        logic signed [31:0] off;
        off = $signed($urandom);
        off = off >>> $urandom_range(0, 31);
        return mean_set + off;
    endfunction

    initial
    begin : stimulus
        logic [31:0] value;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: field extremes and both density cutoffs
        send_sample(32'd0);
        send_sample(32'd1);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'd189812531);
        send_sample(32'd189812532);
        send_sample(32'd124930000);
        send_sample(32'd124937000);

        // zero inv_two_var: density is the prefactor everywhere
        drain_results();
        apply_setting(MEAN_RST, 32'd0, PREFACTOR_RST, LOG_PREFACTOR_RST);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h1234_5678);

        // largest distance and gain, log floor: clamp and full-scale density
        drain_results();
        apply_setting(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFE);

        // opposite corner: mean at minimum, smallest nonzero gain, top log
        drain_results();
        apply_setting(32'h8000_0000, 32'd1, 32'd1, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0001);

        // writes to unused indexes leave the registers alone
        drain_results();
        write_reg(CFG_INDEX_W'(15), 32'hFFFF_FFFF);
        write_reg(CFG_INDEX_W'(8), 32'h0000_0000);
        repeat (2) @(posedge clk);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);

        // random phases, one register setting each
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            random_setting();
            idle_mode = idle_mode_t'(p % 3);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                if (p % 2 == 1 && i == RANDOM_ITEMS / PHASES / 2)
                    drain_results();
                value = ($urandom_range(0, 4) == 0) ? $urandom : near_mean();
                send_sample(value);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
design/gde_pkg.sv
design/gde_quad.sv
design/gde_eval.sv
design/gaussian_density_eval.sv
bench/gde_checker.sv
bench/tb.sv
